// ===== src/bls_pkg.sv =====
// Package for the Bresenham line stepper: widths, command codes and the
// structs passed between the line state core and the top level.
// No dependencies.
package bls_pkg;

    localparam int COORD_BITS = 11;
    localparam int COLOR_BITS = 4;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    // one result transaction
    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    // status from the line core to the top level
    typedef struct packed {
        logic active;
        logic emit;
        logic is_last;
    } core_status_t;

endpackage

// ===== src/bls_line_core.sv =====
// Line state registers and the combinational Bresenham step/load logic.
// Depends on bls_pkg.
module bls_line_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  cmd,
    input  bls_pkg::coord_t       start_x,
    input  bls_pkg::coord_t       start_y,
    input  bls_pkg::coord_t       end_x_in,
    input  bls_pkg::coord_t       end_y_in,
    input  bls_pkg::color_t       draw_color,
    output bls_pkg::pixel_t       pixel,
    output bls_pkg::core_status_t status
);

    bls_pkg::coord_t cur_x_reg, cur_y_reg, stop_x_reg, stop_y_reg;
    bls_pkg::coord_t abs_dx_reg, abs_dy_reg;
    bls_pkg::err_t   error_term_reg;
    logic            step_x_neg_reg, step_y_neg_reg, x_is_major_reg, active_reg;
    bls_pkg::color_t line_color_reg;

    bls_pkg::coord_t cur_x_next, cur_y_next;
    bls_pkg::err_t   error_term_next;
    logic            active_next;

    // load-side values
    logic            ld_x_neg, ld_y_neg, ld_x_major;
    bls_pkg::coord_t ld_adx, ld_ady, ld_major, ld_minor;
    bls_pkg::err_t   ld_err;

    // step-side values
    logic            is_last, minor_moves;
    bls_pkg::coord_t st_major, st_minor, x_moved, y_moved;
    bls_pkg::err_t   err_inc;

    always_comb begin
        ld_x_neg   = end_x_in < start_x;
        ld_y_neg   = end_y_in < start_y;
        ld_adx     = ld_x_neg ? start_x - end_x_in : end_x_in - start_x;
        ld_ady     = ld_y_neg ? start_y - end_y_in : end_y_in - start_y;
        ld_x_major = ld_adx >= ld_ady;
        ld_major   = ld_x_major ? ld_adx : ld_ady;
        ld_minor   = ld_x_major ? ld_ady : ld_adx;
        ld_err     = (bls_pkg::err_t'(ld_minor) <<< 1) - bls_pkg::err_t'(ld_major);
    end

    always_comb begin
        is_last     = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
        st_major    = x_is_major_reg ? abs_dx_reg : abs_dy_reg;
        st_minor    = x_is_major_reg ? abs_dy_reg : abs_dx_reg;
        minor_moves = !error_term_reg[bls_pkg::ERR_BITS-1];
        if (minor_moves) begin
            err_inc = (bls_pkg::err_t'(st_minor) - bls_pkg::err_t'(st_major)) <<< 1;
        end else begin
            err_inc = bls_pkg::err_t'(st_minor) <<< 1;
        end
        x_moved = step_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        y_moved = step_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;

        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        error_term_next = error_term_reg;
        active_next     = active_reg;
        if (is_last) begin
            active_next = 1'b0;
        end else begin
            error_term_next = error_term_reg + err_inc;
            if (x_is_major_reg || minor_moves) begin
                cur_x_next = x_moved;
            end
            if (!x_is_major_reg || minor_moves) begin
                cur_y_next = y_moved;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            stop_x_reg     <= '0;
            stop_y_reg     <= '0;
            abs_dx_reg     <= '0;
            abs_dy_reg     <= '0;
            error_term_reg <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            x_is_major_reg <= 1'b0;
            line_color_reg <= '0;
            active_reg     <= 1'b0;
        end else if (accept) begin
            case (bls_pkg::cmd_t'(cmd))
                bls_pkg::CMD_LOAD: begin
                    cur_x_reg      <= start_x;
                    cur_y_reg      <= start_y;
                    stop_x_reg     <= end_x_in;
                    stop_y_reg     <= end_y_in;
                    abs_dx_reg     <= ld_adx;
                    abs_dy_reg     <= ld_ady;
                    error_term_reg <= ld_err;
                    step_x_neg_reg <= ld_x_neg;
                    step_y_neg_reg <= ld_y_neg;
                    x_is_major_reg <= ld_x_major;
                    line_color_reg <= draw_color;
                    active_reg     <= 1'b1;
                end
                bls_pkg::CMD_STEP: begin
                    if (active_reg) begin
                        cur_x_reg      <= cur_x_next;
                        cur_y_reg      <= cur_y_next;
                        error_term_reg <= error_term_next;
                        active_reg     <= active_next;
                    end
                end
                default: begin
                    active_reg <= active_reg;
                end
            endcase
        end
    end

    assign pixel.x        = cur_x_reg;
    assign pixel.y        = cur_y_reg;
    assign pixel.color    = line_color_reg;
    assign pixel.last     = is_last;
    assign status.active  = active_reg;
    assign status.is_last = is_last;
    assign status.emit    = accept && (bls_pkg::cmd_t'(cmd) == bls_pkg::CMD_STEP)
                            && active_reg;

endmodule

// ===== src/bresenham_line_stepper.sv =====
// Bresenham line stepper, all octants. A step transaction's pixel sits in the
// output register in the cycle after the transaction is accepted.
// Throughput: one transaction per clock, limited by the single add/compare
// of the error update; the input stalls only while an untaken pixel is held.
// Synchronous active-low reset clears the line state and empties the output.
// Depends on bls_pkg and bls_line_core.
module bresenham_line_stepper (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  bls_pkg::coord_t       s_start_x,
    input  bls_pkg::coord_t       s_start_y,
    input  bls_pkg::coord_t       s_end_x_in,
    input  bls_pkg::coord_t       s_end_y_in,
    input  bls_pkg::color_t       s_draw_color,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bls_pkg::coord_t       m_pixel_x,
    output bls_pkg::coord_t       m_pixel_y,
    output bls_pkg::color_t       m_pixel_color,
    output logic                  m_last
);

    logic                  accept;
    logic                  m_valid_reg;
    bls_pkg::pixel_t       pixel;
    bls_pkg::pixel_t       out_reg;
    bls_pkg::core_status_t status;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    bls_line_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cmd        (s_cmd),
        .start_x    (s_start_x),
        .start_y    (s_start_y),
        .end_x_in   (s_end_x_in),
        .end_y_in   (s_end_y_in),
        .draw_color (s_draw_color),
        .pixel      (pixel),
        .status     (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (status.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (status.emit) begin
            out_reg <= pixel;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = out_reg.x;
    assign m_pixel_y     = out_reg.y;
    assign m_pixel_color = out_reg.color;
    assign m_last        = out_reg.last;

    // a load never yields a pixel
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_cmd == bls_pkg::CMD_LOAD) |=> !m_valid)
        else $error("pixel produced by a load transaction");

    // a step on an active line always yields a pixel
    a_step_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_cmd == bls_pkg::CMD_STEP) && status.active |=> m_valid)
        else $error("step on active line produced no pixel");

    // the end point closes the line
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        status.emit && status.is_last |=> !status.active && m_last)
        else $error("line still active after its end point");

endmodule
